// File: rtl/single_wire_sensor_reader_top_macros.svh
// Assertion macros used by the single wire sensor reader core.
`ifndef SINGLE_WIRE_SENSOR_READER_TOP_MACROS_SVH
`define SINGLE_WIRE_SENSOR_READER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Generic clocked assertion with a synchronous active-low reset as disable.
`define SWSR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Shorthand for the block's own clock and reset.
`define SWSR_ASSERT(lbl, prop, msg) \
    `SWSR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define SWSR_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SWSR_ASSERT(lbl, prop, msg)
`endif

`endif

// File: rtl/swsr_pkg.sv
// Types and constants of the single wire sensor reader.
package swsr_pkg;

    localparam int unsigned FRAME_BITS  = 40;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned BITCNT_W    = 6;

    // Item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd3;

    // Register reset values
    localparam logic [15:0] RST_START_LOW = 16'd18000;
    localparam logic [7:0]  RST_RELEASE   = 8'd20;
    localparam logic [7:0]  RST_THRESHOLD = 8'd40;
    localparam logic [15:0] RST_TIMEOUT   = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_DRIVE     = 4'd1,
        PH_RELEASE   = 4'd2,
        PH_WAIT_LOW  = 4'd3,
        PH_RESP_LOW  = 4'd4,
        PH_RESP_HIGH = 4'd5,
        PH_GAP       = 4'd6,
        PH_PULSE     = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_OK       = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_CHECKSUM = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  bit_threshold_ticks;
        logic [15:0] timeout_ticks;
    } t_cfg_regs;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] humidity_int;
        logic [7:0] humidity_frac;
        logic [7:0] temp_int;
        logic [7:0] temp_frac;
    } t_result;

endpackage

// File: rtl/swsr_ifs.sv
// Channel interfaces: command input, result output and register write.
interface swsr_in_if;
    logic valid;
    logic ready;
    logic func;
    logic line_level;
    modport source (output valid, output func, output line_level, input ready);
    modport sink   (input valid, input func, input line_level, output ready);
endinterface

interface swsr_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity_int;
    logic [7:0] humidity_frac;
    logic [7:0] temp_int;
    logic [7:0] temp_frac;
    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output humidity_int, output humidity_frac,
                    output temp_int, output temp_frac, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input humidity_int, input humidity_frac,
                    input temp_int, input temp_frac, output ready);
endinterface

interface swsr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/swsr_cfg_regs.sv
// Configuration register file of the sensor reader.
module swsr_cfg_regs
    import swsr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    swsr_cfg_if.sink        i_cfg,
    output t_cfg_regs       o_regs
);

    t_cfg_regs r_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.start_low_ticks     <= RST_START_LOW;
            r_regs.release_ticks       <= RST_RELEASE;
            r_regs.bit_threshold_ticks <= RST_THRESHOLD;
            r_regs.timeout_ticks       <= RST_TIMEOUT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_START_LOW: r_regs.start_low_ticks     <= i_cfg.data;
                REG_RELEASE:   r_regs.release_ticks       <= i_cfg.data[7:0];
                REG_THRESHOLD: r_regs.bit_threshold_ticks <= i_cfg.data[7:0];
                REG_TIMEOUT:   r_regs.timeout_ticks       <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/swsr_core.sv
// Protocol sequencer: phase state, tick counter, bit shifter and checksum.
`include "single_wire_sensor_reader_top_macros.svh"

module swsr_core
    import swsr_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic      i_func,
    input  logic      i_line_level,
    input  t_cfg_regs i_cfg,
    output logic      o_res_valid,
    output t_result   o_res
);

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF >> (32 - COUNTER_WIDTH);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
    localparam logic [BITCNT_W-1:0] BITS_LAST = BITCNT_W'(FRAME_BITS);

    t_phase                   r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_cnt, n_cnt;
    logic [BITCNT_W-1:0]      r_bits, n_bits;
    logic [39:0]              r_shift, n_shift;
    logic [31:0]              r_held, n_held;
    t_status                  r_status, n_status;
    logic                     n_done;

    logic [COUNTER_WIDTH-1:0] cnt_inc;
    logic [COUNTER_WIDTH-1:0] start_lim;
    logic [COUNTER_WIDTH-1:0] timeout_lim;
    logic [COUNTER_WIDTH-1:0] release_ext;
    logic [COUNTER_WIDTH-1:0] thr_ext;
    logic [31:0]              start_w;
    logic [31:0]              timeout_w;
    logic [BITCNT_W-1:0]      bits_inc;
    logic                     timed_out;
    logic [7:0]               sum8;

    // Start and timeout limits: zero acts as one, anything past the counter range saturates
    always_comb begin
        start_w   = {16'd0, i_cfg.start_low_ticks};
        timeout_w = {16'd0, i_cfg.timeout_ticks};
        if (start_w == 32'd0) begin
            start_w = 32'd1;
        end
        if (start_w > CNT_MAX) begin
            start_w = CNT_MAX;
        end
        if (timeout_w == 32'd0) begin
            timeout_w = 32'd1;
        end
        if (timeout_w > CNT_MAX) begin
            timeout_w = CNT_MAX;
        end
        start_lim   = start_w[COUNTER_WIDTH-1:0];
        timeout_lim = timeout_w[COUNTER_WIDTH-1:0];
    end

    assign release_ext = {{(COUNTER_WIDTH-8){1'b0}}, i_cfg.release_ticks};
    assign thr_ext     = {{(COUNTER_WIDTH-8){1'b0}}, i_cfg.bit_threshold_ticks};
    assign cnt_inc     = (32'(r_cnt) == CNT_MAX) ? r_cnt : r_cnt + CNT_ONE;
    assign timed_out   = (cnt_inc >= timeout_lim);
    assign bits_inc    = r_bits + BITCNT_W'(1);

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_held   = r_held;
        n_status = r_status;
        n_done   = 1'b0;
        sum8     = 8'd0;
        if (i_accept) begin
            if (i_func == FUNC_START) begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_DRIVE;
                    n_cnt   = '0;
                    n_bits  = '0;
                    n_shift = '0;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_DRIVE: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= start_lim) begin
                            n_phase = (i_cfg.release_ticks == 8'd0) ? PH_WAIT_LOW
                                                                    : PH_RELEASE;
                            n_cnt   = '0;
                        end
                    end
                    PH_RELEASE: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= release_ext) begin
                            n_phase = PH_WAIT_LOW;
                            n_cnt   = '0;
                        end
                    end
                    PH_WAIT_LOW, PH_RESP_LOW, PH_RESP_HIGH, PH_GAP, PH_PULSE: begin
                        // Still waiting when the level matches the phase
                        if (i_line_level == ((r_phase == PH_WAIT_LOW) ||
                                             (r_phase == PH_RESP_HIGH) ||
                                             (r_phase == PH_PULSE))) begin
                            n_cnt = cnt_inc;
                            if (timed_out) begin
                                n_phase  = PH_IDLE;
                                n_cnt    = '0;
                                n_bits   = '0;
                                n_status = ST_TIMEOUT;
                                n_done   = 1'b1;
                            end
                        end else begin
                            priority case (r_phase)
                                PH_WAIT_LOW: begin
                                    n_phase = PH_RESP_LOW;
                                    n_cnt   = '0;
                                end
                                PH_RESP_LOW: begin
                                    n_phase = PH_RESP_HIGH;
                                    n_cnt   = '0;
                                end
                                PH_RESP_HIGH: begin
                                    n_phase = PH_GAP;
                                    n_cnt   = '0;
                                end
                                PH_GAP: begin
                                    // first high tick is part of the pulse
                                    n_phase = PH_PULSE;
                                    n_cnt   = CNT_ONE;
                                end
                                default: begin
                                    n_shift = {r_shift[38:0], (r_cnt > thr_ext)};
                                    n_bits  = bits_inc;
                                    if (bits_inc >= BITS_LAST) begin
                                        sum8 = n_shift[39:32] + n_shift[31:24] +
                                               n_shift[23:16] + n_shift[15:8];
                                        if (sum8 == n_shift[7:0]) begin
                                            n_held   = n_shift[39:8];
                                            n_status = ST_OK;
                                        end else begin
                                            n_status = ST_CHECKSUM;
                                        end
                                        n_phase = PH_IDLE;
                                        n_cnt   = '0;
                                        n_bits  = '0;
                                        n_done  = 1'b1;
                                    end else begin
                                        n_phase = PH_GAP;
                                        n_cnt   = '0;
                                    end
                                end
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result of this transaction, from the state it leaves behind
    always_comb begin
        o_res_valid         = i_accept;
        o_res.drive_low     = (n_phase == PH_DRIVE);
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.done_res      = n_done;
        o_res.status        = n_status;
        o_res.humidity_int  = n_held[31:24];
        o_res.humidity_frac = n_held[23:16];
        o_res.temp_int      = n_held[15:8];
        o_res.temp_frac     = n_held[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_bits   <= '0;
            r_shift  <= '0;
            r_held   <= '0;
            r_status <= ST_NONE;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_held   <= n_held;
            r_status <= n_status;
        end
    end

    `SWSR_ASSERT(a_done_goes_idle, o_res_valid && o_res.done_res |=> r_phase == PH_IDLE, "read finished but sequencer not idle")
    `SWSR_ASSERT(a_bits_in_frame, r_bits < BITS_LAST, "bit count ran past the frame")
    `SWSR_ASSERT(a_drive_needs_start, o_res_valid && o_res.drive_low && r_phase == PH_IDLE |-> i_func == FUNC_START, "line driven without a start")
    `SWSR_ASSERT(a_held_only_on_ok, !(o_res_valid && o_res.done_res && o_res.status == ST_OK) |=> $stable(r_held), "held reading changed without a good frame")

endmodule

// File: rtl/swsr_out_q.sv
// Two-entry result queue that decouples the sequencer from the output channel.
module swsr_out_q
    import swsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_res,
    output logic        o_can_push,
    swsr_out_if.source  o_out
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;
    t_result    head;

    assign o_can_push = (r_count != 2'd2);
    assign pop        = o_out.valid && o_out.ready;
    assign head       = r_mem[r_rd_ptr];

    assign o_out.valid         = (r_count != 2'd0);
    assign o_out.drive_low     = head.drive_low;
    assign o_out.busy_res      = head.busy_res;
    assign o_out.done_res      = head.done_res;
    assign o_out.status        = head.status;
    assign o_out.humidity_int  = head.humidity_int;
    assign o_out.humidity_frac = head.humidity_frac;
    assign o_out.temp_int      = head.temp_int;
    assign o_out.temp_frac     = head.temp_frac;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/single_wire_sensor_reader_top.sv
// Top level of the single wire sensor reader (one-wire humidity/temperature sensor).
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+------------
//  i_in     | in  | func, line_level                          | valid/ready
//  o_out    | out | drive_low, busy_res, done_res, status,    | valid/ready
//           |     | humidity_int/frac, temp_int/frac          |
//  i_cfg    | in  | index (8b), data (16b)                    | valid/ready
//
// Each accepted item updates the sequencer state at the edge that accepts it, and
// its result lands in a two-entry output queue. Sustained rate is one item per
// clock while o_out.ready stays high; the queue depth lets a new item in while
// one result waits, and i_in.ready drops only when both entries are full.
// i_rst_n is synchronous, active low; it restores register defaults, idles the
// sequencer and empties the queue. i_cfg.ready is always high.
// Start and timeout limits of zero act as one; above the counter range they saturate at its top.

module single_wire_sensor_reader_top
    import swsr_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 16
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    swsr_in_if.sink    i_in,
    swsr_out_if.source o_out,
    swsr_cfg_if.sink   i_cfg
);

    t_cfg_regs cfg_regs;
    t_result   core_res;
    logic      core_res_valid;
    logic      q_can_push;
    logic      in_accept;

    // Input transaction completes when the queue has room
    assign i_in.ready = q_can_push;
    assign in_accept  = i_in.valid && q_can_push;

    swsr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg_regs)
    );

    swsr_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_func       (i_in.func),
        .i_line_level (i_in.line_level),
        .i_cfg        (cfg_regs),
        .o_res_valid  (core_res_valid),
        .o_res        (core_res)
    );

    swsr_out_q u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (core_res_valid),
        .i_res      (core_res),
        .o_can_push (q_can_push),
        .o_out      (o_out)
    );

endmodule
